### hdl/adwh_pkg.sv
package adwh_pkg;

   localparam int ADWH_CHANNELS = 2;

   localparam int SAMPLE_W = 12;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [SAMPLE_W-1:0] WINDOW_LOW_RESET = 12'd1200;
   localparam logic [SAMPLE_W-1:0] WINDOW_HIGH_RESET = 12'd3500;
   localparam logic [SAMPLE_W-1:0] MARGIN_RESET = 12'd80;

   localparam logic [1:0] REG_WINDOW_LOW = 2'd0;
   localparam logic [1:0] REG_WINDOW_HIGH = 2'd1;
   localparam logic [1:0] REG_MARGIN = 2'd2;

   typedef struct packed {
      logic                channel;
      logic [SAMPLE_W-1:0] sample;
      logic                preload;
   } req_type;

   typedef struct packed {
      logic                out_channel;
      logic [SAMPLE_W-1:0] filtered;
      logic                inside_res;
      logic                entered;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] window_low;
      logic [SAMPLE_W-1:0] window_high;
      logic [SAMPLE_W-1:0] margin;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] filter_value;
      logic                inside_flag;
   } state_type;

   localparam int STATE_W = $bits(state_type);

endpackage

### hdl/adwh_ram.sv
module adwh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   parameter int ADDR_W = 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/adwh_csr.sv
module adwh_csr import adwh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign reg_index = csr_paddr[3:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_WINDOW_LOW: cfg_in.window_low = csr_pwdata[SAMPLE_W-1:0];
            REG_WINDOW_HIGH: cfg_in.window_high = csr_pwdata[SAMPLE_W-1:0];
            REG_MARGIN: cfg_in.margin = csr_pwdata[SAMPLE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_WINDOW_LOW: csr_prdata = CSR_DATA_W'(cfg_ff.window_low);
         REG_WINDOW_HIGH: csr_prdata = CSR_DATA_W'(cfg_ff.window_high);
         REG_MARGIN: csr_prdata = CSR_DATA_W'(cfg_ff.margin);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_low <= WINDOW_LOW_RESET;
         cfg_ff.window_high <= WINDOW_HIGH_RESET;
         cfg_ff.margin <= MARGIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/adwh_update.sv
module adwh_update import adwh_pkg::*; (
   input  req_type   req,
   input  logic      in_range,
   input  state_type old_state,
   input  cfg_type   cfg,
   output state_type new_state,
   output rsp_type   rsp
);

   localparam int CMP_W = SAMPLE_W + 3;

   logic [SAMPLE_W:0]          sum;
   logic [SAMPLE_W-1:0]        avg;
   logic signed [CMP_W-1:0]    val;
   logic signed [CMP_W-1:0]    lo;
   logic signed [CMP_W-1:0]    hi;
   logic signed [CMP_W-1:0]    mg;
   logic                       enter_ok;
   logic                       leave_ok;
   logic                       pre_inside;
   logic                       entered;

   assign sum = {1'b0, old_state.filter_value} + {1'b0, req.sample};
   assign avg = sum[SAMPLE_W:1];
   assign val = signed'(CMP_W'(avg));
   assign lo = signed'(CMP_W'(cfg.window_low));
   assign hi = signed'(CMP_W'(cfg.window_high));
   assign mg = signed'(CMP_W'(cfg.margin));

   assign enter_ok = (val >= lo + mg) && (val <= hi - mg);
   assign leave_ok = (val < lo - mg) || (val > hi + mg);
   assign pre_inside = (req.sample >= cfg.window_low) && (req.sample <= cfg.window_high);

   always_comb begin
      entered = 1'b0;
      if (req.preload) begin
         new_state.filter_value = req.sample;
         new_state.inside_flag = pre_inside;
      end else begin
         new_state.filter_value = avg;
         new_state.inside_flag = old_state.inside_flag;
         if (!old_state.inside_flag) begin
            if (enter_ok) begin
               new_state.inside_flag = 1'b1;
               entered = 1'b1;
            end
         end else if (leave_ok) begin
            new_state.inside_flag = 1'b0;
         end
      end
   end

   always_comb begin
      rsp.out_channel = req.channel;
      if (in_range) begin
         rsp.filtered = new_state.filter_value;
         rsp.inside_res = new_state.inside_flag;
         rsp.entered = entered;
      end else begin
         rsp.filtered = '0;
         rsp.inside_res = 1'b0;
         rsp.entered = 1'b0;
      end
   end

endmodule

### hdl/adwh_state_store.sv
module adwh_state_store import adwh_pkg::*; #(
   parameter int CHANNELS = ADWH_CHANNELS,
   parameter int ADDR_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic [ADDR_W-1:0] cur_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  state_type         wr_data,
   output state_type         cur_state
);

   logic [CHANNELS-1:0] ent_valid_ff;
   logic [CHANNELS-1:0] ent_valid_in;
   logic                lw_valid_ff;
   logic                lw_valid_in;
   logic [ADDR_W-1:0]   lw_addr_ff;
   logic [ADDR_W-1:0]   lw_addr_in;
   state_type           lw_data_ff;
   state_type           lw_data_in;
   logic [STATE_W-1:0]  ram_rd_data;

   adwh_ram #(
      .WIDTH (STATE_W),
      .DEPTH (CHANNELS),
      .ADDR_W(ADDR_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   // The most recent write is forwarded because the memory read for the next
   // transfer may be issued in the same cycle as that write.
   always_comb begin
      if (lw_valid_ff && (lw_addr_ff == cur_addr)) begin
         cur_state = lw_data_ff;
      end else if (ent_valid_ff[cur_addr]) begin
         cur_state = state_type'(ram_rd_data);
      end else begin
         cur_state = '0;
      end
   end

   always_comb begin
      ent_valid_in = ent_valid_ff;
      lw_valid_in = lw_valid_ff;
      lw_addr_in = lw_addr_ff;
      lw_data_in = lw_data_ff;
      if (wr_en) begin
         ent_valid_in[wr_addr] = 1'b1;
         lw_valid_in = 1'b1;
         lw_addr_in = wr_addr;
         lw_data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= '0;
         lw_valid_ff <= 1'b0;
      end else begin
         ent_valid_ff <= ent_valid_in;
         lw_valid_ff <= lw_valid_in;
      end
      lw_addr_ff <= lw_addr_in;
      lw_data_ff <= lw_data_in;
   end

endmodule

### hdl/adc_window_hysteresis_detector_top.sv
// Per-channel sample conditioner: each transfer on req carries a channel, a 12-bit sample
// and a preload bit, and produces exactly one transfer on rsp with the channel's new
// filtered value, its window flag and a one-shot entered event. One sample is taken every
// clock cycle while rsp is not stalled; a request is registered together with the read of
// the per-channel state memory, and the update result is registered on rsp. Samples
// for the same channel may follow back to back; the last state write is forwarded.
// Channels at or above CHANNELS return zero results and change nothing. Window and
// margin registers are at byte offsets 0x0, 0x4 and 0x8 and must be written while idle.
module adc_window_hysteresis_detector_top import adwh_pkg::*; #(
   parameter int CHANNELS = ADWH_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CH_ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   cfg_type              cfg;
   logic                 req_accept;
   logic                 out_free;
   logic                 s1_advance;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   req_type              s1_req_ff;
   req_type              s1_req_in;
   logic                 s1_in_range;
   logic [CH_ADDR_W-1:0] rd_addr;
   logic [CH_ADDR_W-1:0] s1_addr;
   state_type            old_state;
   state_type            new_state;
   rsp_type              s1_rsp;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;

   adwh_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign rd_addr = CH_ADDR_W'(req_payload.channel);
   assign s1_addr = CH_ADDR_W'(s1_req_ff.channel);
   assign s1_in_range = (32'(s1_req_ff.channel) < CHANNELS);

   adwh_state_store #(
      .CHANNELS(CHANNELS),
      .ADDR_W  (CH_ADDR_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (rd_addr),
      .cur_addr (s1_addr),
      .wr_en    (s1_advance && s1_in_range),
      .wr_addr  (s1_addr),
      .wr_data  (new_state),
      .cur_state(old_state)
   );

   adwh_update u_update (
      .req      (s1_req_ff),
      .in_range (s1_in_range),
      .old_state(old_state),
      .cfg      (cfg),
      .new_state(new_state),
      .rsp      (s1_rsp)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_req_in = s1_req_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_req_in = req_payload;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
         rsp_in = s1_rsp;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_req_ff <= s1_req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### dv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import adwh_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int LONG_HOLD = 300;
   localparam int PHASE_ITEMS = 215;
   localparam int PHASES = 7;
   localparam logic [1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic                channel;
      logic [SAMPLE_W-1:0] sample;
      logic                preload;
      logic                typed;
      logic [SAMPLE_W-1:0] filtered;
      logic                inside_res;
      logic                entered;
   } stim_row_type;

   typedef struct packed {
      logic    typed;
      rsp_type want;
   } offer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [SAMPLE_W-1:0] cfg_low = WINDOW_LOW_RESET;
   logic [SAMPLE_W-1:0] cfg_high = WINDOW_HIGH_RESET;
   logic [SAMPLE_W-1:0] cfg_margin = MARGIN_RESET;
   logic [SAMPLE_W-1:0] filt_mem [ADWH_CHANNELS];
   logic                inside_mem [ADWH_CHANNELS];

   offer_type offered_rows [$];
   rsp_type   pending_results [$];
   int        errors = 0;
   int        idle_cycles = 0;
   bit        hold_request = 1'b0;

   stim_row_type directed_rows [0:21] = '{
      '{1'b0, 12'd0,    1'b0, 1'b1, 12'd0,    1'b0, 1'b0},
      '{1'b1, 12'd4095, 1'b1, 1'b1, 12'd4095, 1'b0, 1'b0},
      '{1'b1, 12'd1200, 1'b1, 1'b1, 12'd1200, 1'b1, 1'b0},
      '{1'b0, 12'd3500, 1'b1, 1'b1, 12'd3500, 1'b1, 1'b0},
      '{1'b0, 12'd3501, 1'b1, 1'b1, 12'd3501, 1'b0, 1'b0},
      '{1'b0, 12'd1199, 1'b1, 1'b1, 12'd1199, 1'b0, 1'b0},
      '{1'b0, 12'd0,    1'b1, 1'b1, 12'd0,    1'b0, 1'b0},
      '{1'b0, 12'd2560, 1'b0, 1'b0, 12'd0,    1'b0, 1'b0},
      '{1'b1, 12'd4095, 1'b1, 1'b1, 12'd4095, 1'b0, 1'b0},
      '{1'b0, 12'd4095, 1'b0, 1'b0, 12'd0,    1'b0, 1'b0},
      '{1'b0, 12'd0,    1'b0, 1'b0, 12'd0,    1'b0, 1'b0},
      '{1'b0, 12'd0,    1'b0, 1'b0, 12'd0,    1'b0, 1'b0},
      '{1'b1, 12'd4095, 1'b0, 1'b0, 12'd0,    1'b0, 1'b0},
      '{1'b1, 12'd2745, 1'b0, 1'b0, 12'd0,    1'b0, 1'b0},
      '{1'b1, 12'd3740, 1'b0, 1'b0, 12'd0,    1'b0, 1'b0},
      '{1'b1, 12'd3742, 1'b0, 1'b0, 12'd0,    1'b0, 1'b0},
      '{1'b0, 12'd2730, 1'b0, 1'b0, 12'd0,    1'b0, 1'b0},
      '{1'b1, 12'd1365, 1'b0, 1'b0, 12'd0,    1'b0, 1'b0},
      '{1'b0, 12'd1365, 1'b0, 1'b0, 12'd0,    1'b0, 1'b0},
      '{1'b1, 12'd2730, 1'b0, 1'b0, 12'd0,    1'b0, 1'b0},
      '{1'b0, 12'd4095, 1'b0, 1'b0, 12'd0,    1'b0, 1'b0},
      '{1'b1, 12'd0,    1'b0, 1'b0, 12'd0,    1'b0, 1'b0}
   };

   adc_window_hysteresis_detector_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   initial begin
      for (int i = 0; i < ADWH_CHANNELS; i++) begin
         filt_mem[i] = '0;
         inside_mem[i] = 1'b0;
      end
   end

   function automatic rsp_type condition_sample(req_type it);
      rsp_type r;
      int lo;
      int hi;
      int m;
      int v;
      lo = int'(cfg_low);
      hi = int'(cfg_high);
      m = int'(cfg_margin);
      r.out_channel = it.channel;
      r.entered = 1'b0;
      if (it.preload) begin
         filt_mem[it.channel] = it.sample;
         v = int'(it.sample);
         inside_mem[it.channel] = (v >= lo) && (v <= hi);
      end else begin
         v = (int'(filt_mem[it.channel]) + int'(it.sample)) >> 1;
         filt_mem[it.channel] = v[SAMPLE_W-1:0];
         if (!inside_mem[it.channel]) begin
            if (v >= lo + m && v <= hi - m) begin
               inside_mem[it.channel] = 1'b1;
               r.entered = 1'b1;
            end
         end else if (v < lo - m || v > hi + m) begin
            inside_mem[it.channel] = 1'b0;
         end
      end
      r.filtered = filt_mem[it.channel];
      r.inside_res = inside_mem[it.channel];
      return r;
   endfunction

   function automatic req_type make_sample();
      req_type it;
      int pick;
      int target;
      int corners [6];
      corners[0] = int'(cfg_low) - int'(cfg_margin);
      corners[1] = int'(cfg_low) + int'(cfg_margin);
      corners[2] = int'(cfg_high) - int'(cfg_margin);
      corners[3] = int'(cfg_high) + int'(cfg_margin);
      corners[4] = int'(cfg_low);
      corners[5] = int'(cfg_high);
      it.channel = 1'($urandom_range(0, 1));
      it.preload = ($urandom_range(0, 99) < 8);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         target = int'($urandom_range(0, 4095));
      end else if (pick < 8) begin
         target = corners[$urandom_range(0, 5)] + int'($urandom_range(0, 32)) - 16;
      end else if (pick == 8) begin
         target = 0;
      end else begin
         target = 4095;
      end
      if (target < 0) target = 0;
      if (target > 4095) target = 4095;
      it.sample = target[SAMPLE_W-1:0];
      return it;
   endfunction

   // Monitor: mirrors register writes, predicts each accepted transfer, checks results.
   always @(posedge clock) begin
      offer_type o;
      rsp_type p;
      rsp_type want;
      bit busy;
      if (!reset) begin
         busy = 1'b0;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            busy = 1'b1;
            case (csr_paddr[3:2])
               REG_WINDOW_LOW: cfg_low = csr_pwdata[SAMPLE_W-1:0];
               REG_WINDOW_HIGH: cfg_high = csr_pwdata[SAMPLE_W-1:0];
               REG_MARGIN: cfg_margin = csr_pwdata[SAMPLE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            busy = 1'b1;
            o = offered_rows.pop_front();
            p = condition_sample(req_payload);
            pending_results.push_back(o.typed ? o.want : p);
         end
         if (rsp_valid && !rsp_stall) begin
            busy = 1'b1;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result ch %0d filtered %0d inside %0b entered %0b",
                        $time, rsp_payload.out_channel, rsp_payload.filtered,
                        rsp_payload.inside_res, rsp_payload.entered);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload !== want) begin
                  $display("%0t: expected ch %0d filtered %0d inside %0b entered %0b, %s",
                           $time, want.out_channel, want.filtered, want.inside_res,
                           want.entered, "got:");
                  $display("%0t:   actual ch %0d filtered %0d inside %0b entered %0b",
                           $time, rsp_payload.out_channel, rsp_payload.filtered,
                           rsp_payload.inside_res, rsp_payload.entered);
                  errors++;
               end
            end
         end
         idle_cycles = busy ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // Receiver: stall patterns that change every so often, plus one long hold-off on request.
   initial begin
      int mode;
      int left;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 30);
               2: rsp_stall <= ($urandom_range(0, 99) < 85);
               default: rsp_stall <= left[1];
            endcase
         end
      end
   end

   task automatic send_sample(req_type it, bit typed, rsp_type want, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      offered_rows.push_back({typed, want});
      req_valid <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_results_done();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_access(bit wr, logic [1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!wr && csr_prdata !== data) begin
         $display("%0t: register %0d read expected %0d got %0d", $time, idx, data, csr_prdata);
         errors++;
      end
   endtask

   task automatic read_back_window();
      csr_access(1'b0, REG_WINDOW_LOW, {20'd0, cfg_low});
      csr_access(1'b0, REG_WINDOW_HIGH, {20'd0, cfg_high});
      csr_access(1'b0, REG_MARGIN, {20'd0, cfg_margin});
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_window(int lo, int hi, int m, bit spare);
      wait_results_done();
      csr_access(1'b1, REG_WINDOW_LOW, {20'($urandom), 12'(lo)});
      csr_access(1'b1, REG_WINDOW_HIGH, {20'($urandom), 12'(hi)});
      csr_access(1'b1, REG_MARGIN, {20'($urandom), 12'(m)});
      if (spare) csr_access(1'b1, REG_SPARE, $urandom);
      read_back_window();
   endtask

   initial begin
      req_type it;
      rsp_type want;
      int burst_left;
      int gap;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_back_window();

      foreach (directed_rows[i]) begin
         it = '{directed_rows[i].channel, directed_rows[i].sample, directed_rows[i].preload};
         want = '{directed_rows[i].channel, directed_rows[i].filtered,
                  directed_rows[i].inside_res, directed_rows[i].entered};
         send_sample(it, directed_rows[i].typed, want, 0);
      end
      req_valid <= 1'b0;

      burst_left = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            1: program_window(0, 4095, 0, 1'b1);
            2: program_window(4095, 0, 4095, 1'b0);
            3: program_window(1000, 3000, 4095, 1'b0);
            4, 5: program_window($urandom_range(0, 4095), $urandom_range(0, 4095),
                                 $urandom_range(0, 600), 1'b0);
            6: program_window(2048, 2048, 0, 1'b0);
            default: ;
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 0 && n == 50) begin
               hold_request = 1'b1;
               burst_left = 60;
            end
            if (ph == 4 && n == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               wait_results_done();
            end
            if (burst_left == 0) begin
               gap = $urandom_range(1, 15);
               burst_left = $urandom_range(1, 40);
            end else begin
               gap = 0;
            end
            burst_left--;
            send_sample(make_sample(), 1'b0, '0, gap);
         end
         req_valid <= 1'b0;
      end

      wait_results_done();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
